FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file fbct_checker.
// Depends on nothing; clock and reset names are passed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also active while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/fbct_pkg.sv
// Shared types and constants for the flow byte counter table.
// Used by fbct_slot, the top level and the checker.
package fbct_pkg;

   localparam int FLOW_SLOTS = 64;

   localparam logic [2:0] ST_USER_FILTERED = 3'd0;
   localparam logic [2:0] ST_PORT_FILTERED = 3'd1;
   localparam logic [2:0] ST_CREATED       = 3'd2;
   localparam logic [2:0] ST_UPDATED       = 3'd3;
   localparam logic [2:0] ST_DROPPED       = 3'd4;

   localparam logic [1:0] REG_TARGET_USER = 2'd0;
   localparam logic [1:0] REG_PORT_LOW    = 2'd1;
   localparam logic [1:0] REG_PORT_HIGH   = 2'd2;

   typedef struct packed {
      logic        is_receive;
      logic [31:0] byte_count;
      logic [31:0] user_id;
      logic [31:0] process_id;
      logic [31:0] local_addr;
      logic [31:0] remote_addr;
      logic [15:0] local_port;
      logic [15:0] remote_port;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] sent_total;
      logic [63:0] received_total;
   } rsp_type;

   typedef struct packed {
      logic [31:0] process_id;
      logic [31:0] local_addr;
      logic [31:0] remote_addr;
      logic [15:0] local_port;
      logic [15:0] remote_port;
   } key_type;

   typedef struct packed {
      logic [63:0] sent;
      logic [63:0] received;
   } totals_type;

   typedef struct packed {
      logic       valid;
      key_type    key;
      totals_type totals;
   } entry_type;

   typedef struct packed {
      logic        look;
      logic        update;
      logic        insert;
      logic        is_receive;
      logic [31:0] byte_count;
   } ctrl_type;

   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SUM} state_type;

endpackage

FILE: hdl/flow_byte_counter_table.sv
// Items are handled one at a time: an item is accepted in S_IDLE, the row
// of slots compares all keys at once in S_LOOK, the hit slot's totals are
// gathered in S_SUM, and the response is registered on leaving S_SUM, which
// waits while a held response is stalled; the next item is accepted in S_IDLE.
// Reset (synchronous, active high) clears all slot valid bits, the state
// machine and rsp_valid, and sets the config registers to their defaults.
module flow_byte_counter_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fbct_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fbct_pkg::rsp_type  rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Config registers
   logic [31:0] target_user_ff;
   logic [15:0] port_low_ff;
   logic [15:0] port_high_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_user_ff <= '1;
         port_low_ff    <= '1;
         port_high_ff   <= '1;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            fbct_pkg::REG_TARGET_USER: target_user_ff <= pwdata;
            fbct_pkg::REG_PORT_LOW:    port_low_ff    <= pwdata[15:0];
            fbct_pkg::REG_PORT_HIGH:   port_high_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         fbct_pkg::REG_TARGET_USER: prdata = target_user_ff;
         fbct_pkg::REG_PORT_LOW:    prdata = {16'd0, port_low_ff};
         fbct_pkg::REG_PORT_HIGH:   prdata = {16'd0, port_high_ff};
         default:                   prdata = '0;
      endcase
   end

   // Control
   fbct_pkg::state_type state_ff, state_in;
   fbct_pkg::req_type   req_ff;
   logic [2:0]          status_ff, status_in;
   fbct_pkg::totals_type new_tot_ff;
   logic                rsp_valid_ff;
   fbct_pkg::rsp_type   rsp_ff;

   // Filter decisions from the held item
   logic zero_rx, user_miss, port_hit, counted;
   assign zero_rx   = req_ff.is_receive && (req_ff.byte_count == '0);
   assign user_miss = req_ff.user_id != target_user_ff;
   assign port_hit  = (req_ff.remote_port >= port_low_ff) &&
                      (req_ff.remote_port <= port_high_ff);
   assign counted   = !zero_rx && !user_miss && !port_hit;

   // Slot row
   fbct_pkg::ctrl_type   ctrl;
   fbct_pkg::key_type    bkey;
   fbct_pkg::entry_type  chain [fbct_pkg::FLOW_SLOTS+1];
   fbct_pkg::totals_type results [fbct_pkg::FLOW_SLOTS];
   logic [fbct_pkg::FLOW_SLOTS-1:0] match_vec;
   fbct_pkg::totals_type new_tot;
   fbct_pkg::totals_type hit_tot;
   logic any_hit, full;

   assign bkey = '{process_id: req_ff.process_id, local_addr: req_ff.local_addr,
                   remote_addr: req_ff.remote_addr, local_port: req_ff.local_port,
                   remote_port: req_ff.remote_port};

   assign new_tot.sent     = req_ff.is_receive ? 64'd0 : {32'd0, req_ff.byte_count};
   assign new_tot.received = req_ff.is_receive ? {32'd0, req_ff.byte_count} : 64'd0;

   // New flows enter at slot 0 and push older entries down, so the valid
   // bits form a thermometer and the last slot's valid bit means full.
   assign chain[0] = '{valid: 1'b1, key: bkey, totals: new_tot};
   assign any_hit  = |match_vec;
   assign full     = chain[fbct_pkg::FLOW_SLOTS].valid;

   assign ctrl.look       = state_ff == fbct_pkg::S_LOOK;
   assign ctrl.update     = ctrl.look && counted;
   assign ctrl.insert     = ctrl.look && counted && !any_hit && !full;
   assign ctrl.is_receive = req_ff.is_receive;
   assign ctrl.byte_count = req_ff.byte_count;

   for (genvar i = 0; i < fbct_pkg::FLOW_SLOTS; i++) begin : g_slot
      fbct_slot u_slot (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .key    (bkey),
         .prev   (chain[i]),
         .entry  (chain[i+1]),
         .match  (match_vec[i]),
         .result (results[i])
      );
   end

   // Only the hit slot registered nonzero totals, so an OR gathers them.
   always_comb begin
      hit_tot = '0;
      for (int i = 0; i < fbct_pkg::FLOW_SLOTS; i++) begin
         hit_tot = hit_tot | results[i];
      end
   end

   always_comb begin
      if (zero_rx)        status_in = fbct_pkg::ST_DROPPED;
      else if (user_miss) status_in = fbct_pkg::ST_USER_FILTERED;
      else if (port_hit)  status_in = fbct_pkg::ST_PORT_FILTERED;
      else if (any_hit)   status_in = fbct_pkg::ST_UPDATED;
      else if (full)      status_in = fbct_pkg::ST_DROPPED;
      else                status_in = fbct_pkg::ST_CREATED;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbct_pkg::S_IDLE: if (req_valid) state_in = fbct_pkg::S_LOOK;
         fbct_pkg::S_LOOK: state_in = fbct_pkg::S_SUM;
         fbct_pkg::S_SUM:  if (!rsp_valid_ff || rsp_ready) state_in = fbct_pkg::S_IDLE;
         default:          state_in = fbct_pkg::S_IDLE;
      endcase
   end

   assign req_ready = state_ff == fbct_pkg::S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbct_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == fbct_pkg::S_SUM && state_in == fbct_pkg::S_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (ctrl.look) begin
         status_ff  <= status_in;
         new_tot_ff <= new_tot;
      end
      if (state_ff == fbct_pkg::S_SUM && state_in == fbct_pkg::S_IDLE) begin
         rsp_ff.status <= status_ff;
         case (status_ff)
            fbct_pkg::ST_UPDATED: begin
               rsp_ff.sent_total     <= hit_tot.sent;
               rsp_ff.received_total <= hit_tot.received;
            end
            fbct_pkg::ST_CREATED: begin
               rsp_ff.sent_total     <= new_tot_ff.sent;
               rsp_ff.received_total <= new_tot_ff.received;
            end
            default: begin
               rsp_ff.sent_total     <= '0;
               rsp_ff.received_total <= '0;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/fbct_slot.sv
// One table slot: holds a flow key and its counters, matches the broadcast key.
// Depends on fbct_pkg. Entries shift one slot down on insert.
module fbct_slot (
   input  logic                   clock,
   input  logic                   reset,
   input  fbct_pkg::ctrl_type     ctrl,
   input  fbct_pkg::key_type      key,
   input  fbct_pkg::entry_type    prev,
   output fbct_pkg::entry_type    entry,
   output logic                   match,
   output fbct_pkg::totals_type   result
);

   logic                 valid_ff;
   fbct_pkg::key_type    key_ff;
   fbct_pkg::totals_type tot_ff;
   fbct_pkg::totals_type tot_in;
   fbct_pkg::totals_type result_ff;

   assign match = valid_ff && (key_ff == key);

   always_comb begin
      tot_in = tot_ff;
      if (ctrl.is_receive) begin
         tot_in.received = tot_ff.received + {32'd0, ctrl.byte_count};
      end else begin
         tot_in.sent = tot_ff.sent + {32'd0, ctrl.byte_count};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.insert) begin
         valid_ff <= prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.insert) begin
         key_ff <= prev.key;
         tot_ff <= prev.totals;
      end else if (ctrl.update && match) begin
         tot_ff <= tot_in;
      end
      if (ctrl.look) begin
         result_ff <= match ? tot_in : '0;
      end
   end

   assign entry  = '{valid: valid_ff, key: key_ff, totals: tot_ff};
   assign result = result_ff;

endmodule

FILE: hdl/fbct_checker.sv
// Port-level checker for flow_byte_counter_table, bound to the top level.
// Depends on fbct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbct_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fbct_pkg::rsp_type rsp_data
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped while stalled")
   `ASSERT_CLK(a_status_range, clock, reset, rsp_valid |-> rsp_data.status <= fbct_pkg::ST_DROPPED, "bad status")
   `ASSERT_CLK(a_filtered_zero, clock, reset, rsp_valid && (rsp_data.status == fbct_pkg::ST_USER_FILTERED || rsp_data.status == fbct_pkg::ST_PORT_FILTERED || rsp_data.status == fbct_pkg::ST_DROPPED) |-> rsp_data.sent_total == '0 && rsp_data.received_total == '0, "nonzero totals on unstored item")
   `ASSERT_CLK(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "item accepted while busy")

endmodule

bind flow_byte_counter_table fbct_checker u_fbct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
